// ===== rtl/pcdr_pkg.sv =====
`default_nettype none

package pcdr_pkg;

  // Raw pointer event codes.
  typedef enum logic [1:0] {
    FUNC_PRESS   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_MOVE    = 2'd2,
    FUNC_DOUBLE  = 2'd3
  } func_e;

  // Result kinds.
  typedef enum logic [3:0] {
    KIND_DOWN       = 4'd0,
    KIND_UP         = 4'd1,
    KIND_CLICK      = 4'd2,
    KIND_DOUBLE     = 4'd3,
    KIND_MOTION     = 4'd4,
    KIND_DRAG_START = 4'd5,
    KIND_DRAG       = 4'd6,
    KIND_DRAG_END   = 4'd7,
    KIND_CANCEL     = 4'd8
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DRAG_THRESHOLD = 1'b0,
    REG_MIN_DRAG_TIME  = 1'b1
  } reg_e;

  // Button codes.
  localparam logic [2:0] BTN_NONE  = 3'd0;
  localparam logic [2:0] BTN_LEFT  = 3'd1;
  localparam logic [2:0] BTN_RIGHT = 3'd3;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;

  localparam logic [CFG_W-1:0] DRAG_THRESHOLD_RESET = 16'd32;
  localparam logic [CFG_W-1:0] MIN_DRAG_TIME_RESET  = 16'd100;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  // One classified event: up to three results that share button and positions.
  typedef struct packed {
    logic [1:0]              last_idx;
    kind_e                   kind0;
    kind_e                   kind1;
    kind_e                   kind2;
    logic [2:0]              button;
    logic signed [POS_W-1:0] cur_x;
    logic signed [POS_W-1:0] cur_y;
    logic signed [POS_W-1:0] press_x;
    logic signed [POS_W-1:0] press_y;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/pcdr_front.sv =====
`default_nettype none

module pcdr_front import pcdr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic [1:0]              func_i,
  input  wire logic [2:0]              button_i,
  input  wire logic                    meta_held_i,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic [TIME_W-1:0]       time_ms_i,
  output      logic                    push_valid_o,
  input  wire logic                    push_ready_i,
  output      entry_t                  push_entry_o
);

  logic [CFG_W-1:0]        drag_threshold_q;
  logic [CFG_W-1:0]        min_drag_time_q;
  logic signed [POS_W-1:0] press_x_q, press_x_d;
  logic signed [POS_W-1:0] press_y_q, press_y_d;
  logic [TIME_W-1:0]       press_time_q, press_time_d;
  logic button_down_q, button_down_d;
  logic dragging_q, dragging_d;
  logic release_as_right_q, release_as_right_d;
  logic release_after_double_q, release_after_double_d;

  logic              accept;
  logic [POS_W:0]    dx, dy, ax, ay;
  logic [TIME_W-1:0] dur;
  logic              beyond;
  logic              too_short;
  entry_t            entry;

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i & in_ready_o;
  assign push_valid_o = in_valid_i;
  assign push_entry_o = entry;

  // Distance from the press position on each axis, and drag duration.
  assign dx = {pos_x_i[POS_W-1], pos_x_i} - {press_x_q[POS_W-1], press_x_q};
  assign dy = {pos_y_i[POS_W-1], pos_y_i} - {press_y_q[POS_W-1], press_y_q};
  assign ax = dx[POS_W] ? (~dx + 1'b1) : dx;
  assign ay = dy[POS_W] ? (~dy + 1'b1) : dy;
  assign beyond = (ax > {1'b0, drag_threshold_q}) || (ay > {1'b0, drag_threshold_q});
  assign dur = time_ms_i - press_time_q;
  assign too_short = dur < {{(TIME_W-CFG_W){1'b0}}, min_drag_time_q};

  // Classify the event into its result list and the next state.
  always_comb begin
    press_x_d              = press_x_q;
    press_y_d              = press_y_q;
    press_time_d           = press_time_q;
    button_down_d          = button_down_q;
    dragging_d             = dragging_q;
    release_as_right_d     = release_as_right_q;
    release_after_double_d = release_after_double_q;

    entry          = '0;
    entry.kind0    = KIND_DOWN;
    entry.kind1    = KIND_DOWN;
    entry.kind2    = KIND_DOWN;
    entry.button   = button_i;
    entry.cur_x    = pos_x_i;
    entry.cur_y    = pos_y_i;
    entry.press_x  = press_x_q;
    entry.press_y  = press_y_q;

    case (func_e'(func_i))
      FUNC_PRESS: begin
        if (meta_held_i) begin
          entry.button       = BTN_RIGHT;
          release_as_right_d = 1'b1;
        end
        press_x_d      = pos_x_i;
        press_y_d      = pos_y_i;
        press_time_d   = time_ms_i;
        button_down_d  = 1'b1;
        entry.kind0    = KIND_DOWN;
        entry.last_idx = 2'd0;
      end
      FUNC_RELEASE: begin
        release_as_right_d = 1'b0;
        if (release_as_right_q && button_i == BTN_LEFT) begin
          entry.button = BTN_RIGHT;
        end
        if (dragging_q) begin
          dragging_d = 1'b0;
          if (too_short) begin
            entry.kind0 = KIND_CANCEL;
            if (!beyond) begin
              entry.kind1    = KIND_CLICK;
              entry.kind2    = KIND_UP;
              entry.last_idx = 2'd2;
            end else begin
              entry.kind1    = KIND_UP;
              entry.last_idx = 2'd1;
            end
          end else begin
            entry.kind0    = KIND_DRAG_END;
            entry.kind1    = KIND_UP;
            entry.last_idx = 2'd1;
          end
        end else if (!release_after_double_q) begin
          entry.kind0    = KIND_CLICK;
          entry.kind1    = KIND_UP;
          entry.last_idx = 2'd1;
        end else begin
          entry.kind0    = KIND_UP;
          entry.last_idx = 2'd0;
        end
        button_down_d          = 1'b0;
        release_after_double_d = 1'b0;
      end
      FUNC_MOVE: begin
        if (!dragging_q && button_down_q && beyond) begin
          dragging_d     = 1'b1;
          entry.kind0    = KIND_DRAG_START;
          entry.kind1    = KIND_DRAG;
          entry.last_idx = 2'd1;
        end else begin
          entry.kind0    = dragging_q ? KIND_DRAG : KIND_MOTION;
          entry.last_idx = 2'd0;
        end
      end
      FUNC_DOUBLE: begin
        entry.kind0            = KIND_DOWN;
        entry.kind1            = KIND_DOUBLE;
        entry.last_idx         = 2'd1;
        release_after_double_d = 1'b1;
      end
      default: begin
        entry.last_idx = 2'd0;
      end
    endcase
  end

  // Configuration registers and recognizer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_threshold_q       <= DRAG_THRESHOLD_RESET;
      min_drag_time_q        <= MIN_DRAG_TIME_RESET;
      press_x_q              <= '0;
      press_y_q              <= '0;
      press_time_q           <= '0;
      button_down_q          <= 1'b0;
      dragging_q             <= 1'b0;
      release_as_right_q     <= 1'b0;
      release_after_double_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_DRAG_THRESHOLD: drag_threshold_q <= cfg_data_i;
          REG_MIN_DRAG_TIME:  min_drag_time_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        press_x_q              <= press_x_d;
        press_y_q              <= press_y_d;
        press_time_q           <= press_time_d;
        button_down_q          <= button_down_d;
        dragging_q             <= dragging_d;
        release_as_right_q     <= release_as_right_d;
        release_after_double_q <= release_after_double_d;
      end
    end
  end

  // A drag can only be in progress while a button is held.
  a_drag_needs_button: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dragging_q |-> button_down_q)
    else $error("dragging without a held button");

  // A release always ends the drag and the held button.
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_RELEASE) |=> (!dragging_q && !button_down_q))
    else $error("release left drag or button state set");

  // A new drag start always comes with a drag step in the same event.
  a_start_then_drag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && entry.kind0 == KIND_DRAG_START) |->
      (entry.kind1 == KIND_DRAG && entry.last_idx == 2'd1))
    else $error("drag start not followed by a drag step");

endmodule

`default_nettype wire

// ===== rtl/pcdr_queue.sv =====
`default_nettype none

module pcdr_queue import pcdr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_valid_i,
  output      logic   push_ready_o,
  input  wire entry_t push_entry_i,
  output      logic   pop_valid_o,
  input  wire logic   pop_ready_i,
  output      entry_t pop_entry_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != FULL_CNT;
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = mem_q[rptr_q];
  assign push = push_valid_i & push_ready_o;
  assign pop  = pop_valid_o & pop_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue fill count above depth");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on a lone write");

endmodule

`default_nettype wire

// ===== rtl/pcdr_back.sv =====
`default_nettype none

module pcdr_back import pcdr_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    head_valid_i,
  input  wire entry_t                  head_i,
  output      logic                    pop_o,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic [3:0]              kind_o,
  output      logic [2:0]              out_button_o,
  output      logic signed [POS_W-1:0] out_x_o,
  output      logic signed [POS_W-1:0] out_y_o,
  output      logic                    last_o
);

  logic [1:0] idx_q;
  kind_e      kind;
  logic       out_take;

  assign out_valid_o = head_valid_i;
  assign out_take    = out_valid_o & out_ready_i;
  assign last_o      = idx_q == head_i.last_idx;
  assign pop_o       = out_take & last_o;
  assign kind_o      = kind;

  // Pick the current result of the head entry.
  always_comb begin
    case (idx_q)
      2'd0:    kind = head_i.kind0;
      2'd1:    kind = head_i.kind1;
      default: kind = head_i.kind2;
    endcase
  end

  // Button and position depend on the result kind.
  always_comb begin
    out_button_o = head_i.button;
    out_x_o      = head_i.cur_x;
    out_y_o      = head_i.cur_y;
    case (kind)
      KIND_CLICK, KIND_DRAG_START: begin
        out_x_o = head_i.press_x;
        out_y_o = head_i.press_y;
      end
      KIND_CANCEL: begin
        out_button_o = BTN_NONE;
        out_x_o      = '0;
        out_y_o      = '0;
      end
      default: ;
    endcase
  end

  // Result index within the head entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_take) begin
      idx_q <= last_o ? 2'd0 : idx_q + 1'b1;
    end
  end

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> idx_q <= head_i.last_idx)
    else $error("result index beyond the entry's result count");

  a_up_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind == KIND_UP) |-> last_o)
    else $error("up result not marked last");

endmodule

`default_nettype wire

// ===== rtl/pointer_click_drag_recognizer_core.sv =====
`default_nettype none

// Pointer click and drag recognizer. Raw press, release, move and double-click
// events go in on the input channel; down, up, click, double-click, motion,
// drag start, drag, drag end and cancel results come out on the output
// channel, one result per cycle while out_ready_i is high, with last set on
// the final result of each event. A press yields one result, a move one or
// two, a double-click two and a release one to three (only the up result
// after a double-click unless a drag is in progress), so an event holds the
// output side for one transfer per result; its first result is visible once
// the event is at the head of the entry queue. The front end classifies an
// event and updates the recognizer state in the cycle it is accepted, so it
// takes a new event every cycle while the entry queue (QUEUE_DEPTH entries, at
// least two) has room; the output sequencer, at one result per cycle while
// out_ready_i is high, sets the sustained rate. Configuration writes take
// effect at once and should be made while no event is in flight.
module pointer_click_drag_recognizer_core import pcdr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_data_i,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic [1:0]              func_i,
  input  wire logic [2:0]              button_i,
  input  wire logic                    meta_held_i,
  input  wire logic signed [POS_W-1:0] pos_x_i,
  input  wire logic signed [POS_W-1:0] pos_y_i,
  input  wire logic [TIME_W-1:0]       time_ms_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic [3:0]              kind_o,
  output      logic [2:0]              out_button_o,
  output      logic signed [POS_W-1:0] out_x_o,
  output      logic signed [POS_W-1:0] out_y_o,
  output      logic                    last_o
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   head_valid, pop;
  entry_t head_entry;

  pcdr_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .button_i,
    .meta_held_i,
    .pos_x_i,
    .pos_y_i,
    .time_ms_i,
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  pcdr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (pop),
    .pop_entry_o  (head_entry)
  );

  pcdr_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .kind_o,
    .out_button_o,
    .out_x_o,
    .out_y_o,
    .last_o
  );

endmodule

`default_nettype wire
